FILE: rtl/ftm_pkg.sv
// Shared types, constants and helpers for the filtered target match counter.
// Depends on nothing; every other file refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package ftm_pkg;

    // Item command codes
    typedef enum logic {
        CMD_TARGET = 1'b0,
        CMD_VOXEL  = 1'b1
    } t_cmd;

    localparam int ID_W        = 8;
    localparam int SUB_W       = 4;
    localparam int KEY_W       = ID_W + SUB_W;
    localparam int KEY_COUNT   = 1 << KEY_W;

    // Bitmaps are stored as rows of ROW_BITS flags
    localparam int BIT_SEL_W   = 6;
    localparam int ROW_BITS    = 1 << BIT_SEL_W;
    localparam int ROW_ADDR_W  = KEY_W - BIT_SEL_W;
    localparam int ROWS        = 1 << ROW_ADDR_W;

    localparam int MATCH_W     = 17;
    localparam int DISTINCT_W  = 13;
    localparam longint MATCH_MAX = (longint'(1) << MATCH_W) - 1;

    localparam int SECTIONS_PER_CHUNK_DEF = 16;

    localparam int OUTQ_DEPTH  = 3;
    localparam int OUTQ_PTR_W  = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CNT_W  = $clog2(OUTQ_DEPTH + 1);

    localparam logic [7:0] NIBBLE_LO = 8'h0F;
    localparam logic [7:0] NIBBLE_HI = 8'hF0;

    typedef logic [ROW_BITS-1:0]   t_row;
    typedef logic [ROW_ADDR_W-1:0] t_row_addr;

    typedef struct packed {
        logic [MATCH_W-1:0]    match_count;
        logic [DISTINCT_W-1:0] distinct_count;
    } t_result;

    // Common voxel types that are never scored
    function automatic logic is_common(input logic [ID_W-1:0] id,
                                       input logic [SUB_W-1:0] sub);
        is_common = (id == 8'd0) || (id == 8'd1 && sub == 4'd0) ||
                    (id == 8'd2) || (id == 8'd3) || (id == 8'd8) ||
                    (id == 8'd9) || (id == 8'd12) || (id == 8'd18) ||
                    (id == 8'd24);
    endfunction

endpackage

`default_nettype wire

FILE: rtl/ftm_if.sv
// Valid/ready channel interfaces for voxel/target items and count results.
// Depends on ftm_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface ftm_in_if;
    logic                          valid;
    logic                          ready;
    logic                          cmd;
    logic [ftm_pkg::KEY_W-1:0]     target_key;
    logic                          target_value;
    logic [ftm_pkg::ID_W-1:0]      block_id;
    logic [7:0]                    data_byte;
    logic                          odd_half;
    logic                          first_of_chunk;
    logic                          last_of_chunk;

    modport source (
        output valid, cmd, target_key, target_value, block_id, data_byte,
               odd_half, first_of_chunk, last_of_chunk,
        input  ready
    );
    modport sink (
        input  valid, cmd, target_key, target_value, block_id, data_byte,
               odd_half, first_of_chunk, last_of_chunk,
        output ready
    );
endinterface

interface ftm_out_if;
    logic                              valid;
    logic                              ready;
    logic [ftm_pkg::MATCH_W-1:0]       match_count;
    logic [ftm_pkg::DISTINCT_W-1:0]    distinct_count;

    modport source (output valid, match_count, distinct_count, input ready);
    modport sink   (input  valid, match_count, distinct_count, output ready);
endinterface

`default_nettype wire

FILE: rtl/ftm_bitmap.sv
// 4096-flag bitmap held as a row memory with registered read data,
// per-row valid flags (cleared at reset or flush) and write-to-read forwarding.
// Depends on ftm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ftm_bitmap (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_rd_en,
    input  wire ftm_pkg::t_row_addr i_rd_row,
    input  wire ftm_pkg::t_row_addr i_cur_row,
    input  wire logic               i_flush,
    input  wire logic               i_wr_en,
    input  wire ftm_pkg::t_row      i_wr_data,
    output ftm_pkg::t_row           o_cur_data
);

    ftm_pkg::t_row              r_mem [ftm_pkg::ROWS];
    ftm_pkg::t_row              r_rdata;
    logic [ftm_pkg::ROWS-1:0]   r_valid;
    logic [ftm_pkg::ROWS-1:0]   n_valid;
    logic                       r_fwd_en;
    ftm_pkg::t_row_addr         r_fwd_row;
    ftm_pkg::t_row              r_fwd_data;

    // memory port: read-before-write, registered read data
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rdata <= r_mem[i_rd_row];
        end
        if (i_wr_en) begin
            r_mem[i_cur_row] <= i_wr_data;
        end
    end

    // current row as seen by the item in the update stage
    always_comb begin
        if (i_flush) begin
            o_cur_data = '0;
        end else if (r_fwd_en && r_fwd_row == i_cur_row) begin
            o_cur_data = r_fwd_data;
        end else if (r_valid[i_cur_row]) begin
            o_cur_data = r_rdata;
        end else begin
            o_cur_data = '0;
        end
    end

    always_comb begin
        n_valid = i_flush ? '0 : r_valid;
        if (i_wr_en) begin
            n_valid[i_cur_row] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_fwd_en <= 1'b0;
        end else begin
            r_valid  <= n_valid;
            r_fwd_en <= i_wr_en;
        end
        r_fwd_row  <= i_cur_row;
        r_fwd_data <= i_wr_data;
    end

endmodule

`default_nettype wire

FILE: rtl/ftm_outq.sv
// Small result queue that decouples the count pipeline from the receiver.
// Depends on ftm_pkg and ftm_out_if.
`timescale 1ns / 1ps
`default_nettype none

module ftm_outq (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_push,
    input  wire ftm_pkg::t_result                 i_data,
    output logic [ftm_pkg::OUTQ_CNT_W-1:0]        o_count,
    ftm_out_if.source                             o_result
);

    localparam int DEPTH = ftm_pkg::OUTQ_DEPTH;

    ftm_pkg::t_result                   r_mem [DEPTH];
    logic [ftm_pkg::OUTQ_PTR_W-1:0]     r_wr_ptr, n_wr_ptr;
    logic [ftm_pkg::OUTQ_PTR_W-1:0]     r_rd_ptr, n_rd_ptr;
    logic [ftm_pkg::OUTQ_CNT_W-1:0]     r_count, n_count;
    logic                               pop;

    assign pop                     = o_result.valid && o_result.ready;
    assign o_result.valid          = (r_count != '0);
    assign o_result.match_count    = r_mem[r_rd_ptr].match_count;
    assign o_result.distinct_count = r_mem[r_rd_ptr].distinct_count;
    assign o_count                 = r_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == ftm_pkg::OUTQ_PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == ftm_pkg::OUTQ_PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({i_push, pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/filtered_target_match_counter.sv
// Filtered target match counter: scores voxels against a loadable target bitmap.
// Depends on ftm_pkg, ftm_if, ftm_bitmap and ftm_outq.
//
// Usage:
//   i_item carries one transaction per voxel (cmd = CMD_VOXEL) or per target
//   bitmap write (cmd = CMD_TARGET). A voxel's key is {block_id, sub-id}; the
//   sub-id is the low or high nibble of data_byte per odd_half. Common ids are
//   skipped. A key found in the target bitmap bumps match_count; if it is also
//   new to the seen bitmap it is marked and distinct_count bumps.
//   first_of_chunk clears the seen bitmap and both counts before scoring;
//   last_of_chunk pushes one o_result transaction with both counts.
// Timing:
//   One item per cycle while i_item.ready is high. Stage 0 reads the bitmap
//   rows, stage 1 sees the row data, updates counts and writes the row
//   back; the last write is forwarded to the next item. A result passes
//   through the stage 1 registers and the result queue before it shows
//   on o_result. The rate is set by the single read-modify-write per
//   bitmap per cycle.
// Reset and stall:
//   Reset clears the row-valid flags of both bitmaps, so both read as all
//   clear at once; no sweep is needed. A chunk flush clears the seen rows the
//   same way. Results wait in a three-entry queue; i_item.ready drops when
//   the queued results plus the in-flight result would fill the queue.
`timescale 1ns / 1ps
`default_nettype none

module filtered_target_match_counter #(
    parameter int SECTIONS_PER_CHUNK = ftm_pkg::SECTIONS_PER_CHUNK_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    ftm_in_if.sink      i_item,
    ftm_out_if.source   o_result
);

    // saturation point of the match count
    localparam longint CAP_FULL = longint'(SECTIONS_PER_CHUNK) * ftm_pkg::KEY_COUNT;
    localparam logic [ftm_pkg::MATCH_W-1:0] MATCH_CAP =
        (CAP_FULL > ftm_pkg::MATCH_MAX) ? ftm_pkg::MATCH_W'(ftm_pkg::MATCH_MAX)
                                        : ftm_pkg::MATCH_W'(CAP_FULL);

    // ---------------- stage 0: decode and issue row reads ----------------
    logic                               s0_accept;
    logic [ftm_pkg::SUB_W-1:0]          s0_sub;
    logic [ftm_pkg::KEY_W-1:0]          s0_key;
    logic                               s0_common;

    assign s0_accept = i_item.valid && i_item.ready;

    always_comb begin
        if (i_item.odd_half) begin
            s0_sub = ftm_pkg::SUB_W'((i_item.data_byte & ftm_pkg::NIBBLE_HI) >> ftm_pkg::SUB_W);
        end else begin
            s0_sub = ftm_pkg::SUB_W'(i_item.data_byte & ftm_pkg::NIBBLE_LO);
        end
        if (i_item.cmd == ftm_pkg::CMD_VOXEL) begin
            s0_key = {i_item.block_id, s0_sub};
        end else begin
            s0_key = i_item.target_key;
        end
        s0_common = ftm_pkg::is_common(i_item.block_id, s0_sub);
    end

    // ---------------- stage 1 registers ----------------
    logic                               r_s1_vld;
    logic                               r_s1_cmd;
    ftm_pkg::t_row_addr                 r_s1_row;
    logic [ftm_pkg::BIT_SEL_W-1:0]      r_s1_bit;
    logic                               r_s1_skip;
    logic                               r_s1_first;
    logic                               r_s1_last;
    logic                               r_s1_tval;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= s0_accept;
        end
        if (s0_accept) begin
            r_s1_cmd   <= i_item.cmd;
            r_s1_row   <= s0_key[ftm_pkg::KEY_W-1:ftm_pkg::BIT_SEL_W];
            r_s1_bit   <= s0_key[ftm_pkg::BIT_SEL_W-1:0];
            r_s1_skip  <= s0_common;
            r_s1_first <= i_item.first_of_chunk;
            r_s1_last  <= i_item.last_of_chunk;
            r_s1_tval  <= i_item.target_value;
        end
    end

    // ---------------- stage 1: score and write back ----------------
    logic                               s1_voxel;
    logic                               s1_flush;
    ftm_pkg::t_row                      s1_mask;
    ftm_pkg::t_row                      trow, srow;
    logic                               s1_hit, s1_new;
    logic                               t_wr_en, s_wr_en;
    ftm_pkg::t_row                      t_wr_data, s_wr_data;

    assign s1_voxel  = r_s1_vld && (r_s1_cmd == ftm_pkg::CMD_VOXEL);
    assign s1_flush  = s1_voxel && r_s1_first;
    assign s1_mask   = ftm_pkg::ROW_BITS'(1) << r_s1_bit;
    assign s1_hit    = s1_voxel && !r_s1_skip && trow[r_s1_bit];
    assign s1_new    = s1_hit && !srow[r_s1_bit];

    assign t_wr_en   = r_s1_vld && (r_s1_cmd == ftm_pkg::CMD_TARGET);
    assign t_wr_data = r_s1_tval ? (trow | s1_mask) : (trow & ~s1_mask);
    assign s_wr_en   = s1_new;
    assign s_wr_data = srow | s1_mask;

    ftm_bitmap u_target (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (s0_accept),
        .i_rd_row   (s0_key[ftm_pkg::KEY_W-1:ftm_pkg::BIT_SEL_W]),
        .i_cur_row  (r_s1_row),
        .i_flush    (1'b0),
        .i_wr_en    (t_wr_en),
        .i_wr_data  (t_wr_data),
        .o_cur_data (trow)
    );

    // seen rows drop to clear on a chunk start
    ftm_bitmap u_seen (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (s0_accept),
        .i_rd_row   (s0_key[ftm_pkg::KEY_W-1:ftm_pkg::BIT_SEL_W]),
        .i_cur_row  (r_s1_row),
        .i_flush    (s1_flush),
        .i_wr_en    (s_wr_en),
        .i_wr_data  (s_wr_data),
        .o_cur_data (srow)
    );

    // ---------------- counters ----------------
    logic [ftm_pkg::MATCH_W-1:0]        r_match, n_match, base_match;
    logic [ftm_pkg::DISTINCT_W-1:0]     r_distinct, n_distinct, base_distinct;

    always_comb begin
        base_match    = s1_flush ? '0 : r_match;
        base_distinct = s1_flush ? '0 : r_distinct;
        n_match       = r_match;
        n_distinct    = r_distinct;
        if (s1_voxel) begin
            n_match    = (s1_hit && base_match < MATCH_CAP) ? base_match + 1'b1 : base_match;
            n_distinct = s1_new ? base_distinct + 1'b1 : base_distinct;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match    <= '0;
            r_distinct <= '0;
        end else begin
            r_match    <= n_match;
            r_distinct <= n_distinct;
        end
    end

    // ---------------- result queue ----------------
    logic                               push;
    ftm_pkg::t_result                   push_data;
    logic [ftm_pkg::OUTQ_CNT_W-1:0]     q_count;
    logic [ftm_pkg::OUTQ_CNT_W:0]       q_demand;

    assign push                     = s1_voxel && r_s1_last;
    assign push_data.match_count    = n_match;
    assign push_data.distinct_count = n_distinct;

    // queued results plus the one that may leave stage 1 this cycle
    assign q_demand     = {1'b0, q_count} + (ftm_pkg::OUTQ_CNT_W + 1)'(push);
    assign i_item.ready = (q_demand < (ftm_pkg::OUTQ_CNT_W + 1)'(ftm_pkg::OUTQ_DEPTH));

    ftm_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_data   (push_data),
        .o_count  (q_count),
        .o_result (o_result)
    );

endmodule

`default_nettype wire
